[rtl/rcpwd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpwd_pkg: shared types, constants and window helpers
// Field widths, status and phase codes, pulse class and result beats, and the
// fixed-point window bound functions used by the pulse-width decoder.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

    // Field widths
    localparam int CLK_W   = 16;   // encoder clock period, us
    localparam int WIDTH_W = 24;   // measured pulse width, us
    localparam int CODE_W  = 12;   // emitted code word
    localparam int BOUND_W = 17;   // floor(clk*6/5) needs 17 bits for a 16-bit clk
    localparam int GAP_W   = 20;   // 10 * clk

    // Defaults for the top-level parameters
    localparam int SYNC_TRIES_DEF  = 13;
    localparam int DATA_BITS_DEF   = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CLK_W-1:0] CLK_PERIOD_RESET = 16'd333;

    // x/5 as (x * ceil(2^24/5)) >> 24, exact for x < 2^22
    localparam int          RECIP_SHIFT = 24;
    localparam int          RECIP_W     = 22;
    localparam int          DIV_IN_W    = CLK_W + 3;
    localparam logic [RECIP_W-1:0] RECIP_FIFTH = 22'd3355444;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_NOSYNC  = 2'd2,
        ST_NODATA  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_GAP  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Classified input beat handed from front to back
    typedef struct packed {
        logic timeout;
        logic high;
        logic sync_hit;
        logic gap_over;
        logic bit_one;
        logic bit_zero;
    } pulse_class_t;

    // Result beat
    typedef struct packed {
        status_t            status;
        logic [CODE_W-1:0]  code;
    } result_t;

    function automatic logic [BOUND_W-1:0] div5(input logic [DIV_IN_W-1:0] x);
        logic [DIV_IN_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, x} * {{DIV_IN_W{1'b0}}, RECIP_FIFTH};
        return prod[RECIP_SHIFT +: BOUND_W];
    endfunction

    // floor(clk*4/5)
    function automatic logic [BOUND_W-1:0] lower_of(input logic [CLK_W-1:0] clk);
        return div5({1'b0, clk, 2'b00});
    endfunction

    // floor(clk*6/5)
    function automatic logic [BOUND_W-1:0] upper_of(input logic [CLK_W-1:0] clk);
        logic [DIV_IN_W-1:0] x;
        x = {1'b0, clk, 2'b00} + {2'b00, clk, 1'b0};
        return div5(x);
    endfunction

    // 10 * clk
    function automatic logic [GAP_W-1:0] gap_of(input logic [CLK_W-1:0] clk);
        logic [GAP_W-1:0] c;
        c = GAP_W'(clk);
        return (c << 3) + (c << 1);
    endfunction

endpackage

[rtl/remote_code_pulse_width_decoder.sv]
// ----------------------------------------------------------------------------
// remote_code_pulse_width_decoder: 12-bit pulse-width remote code decoder
// Takes measured line pulses or timeout events and emits a status and word
// for each completed frame or error.
// ----------------------------------------------------------------------------
// The decoder takes one beat per clock: push is honored whenever the two-entry
// class queue between the classifier and the sequencer has room, and the
// sequencer retires one classified beat per cycle while the result queue has
// room, so with pop held high the sustained rate is one beat per cycle. A
// result reaches the result ports once the beat completing it has passed the
// class queue and sequencer into the result queue. Window bounds are derived
// from clock_period_us at the write (one reciprocal multiply for each of the
// lower and upper bounds) and apply to beats pushed from the next cycle on.
// Every result, good or bad, returns the decoder to sync hunting.
// ----------------------------------------------------------------------------
module remote_code_pulse_width_decoder
    import rcpwd_pkg::*;
#(
    parameter int SYNC_TRIES  = SYNC_TRIES_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // config
    input  logic               cfg_wr_en,
    input  logic [CLK_W-1:0]   clock_period_us,
    // input queue side
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic               pulse_level,
    input  logic [WIDTH_W-1:0] pulse_width_us,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic [CODE_W-1:0]  code_word
);

    localparam int CLS_W = $bits(pulse_class_t);
    localparam int RES_W = $bits(result_t);

    pulse_class_t     cls_in, cls_head;
    logic [CLS_W-1:0] cls_head_bits;
    logic             cls_empty, cls_pop;
    logic             res_full, res_push;
    result_t          res_in, res_head;
    logic [RES_W-1:0] res_head_bits;

    // classifier
    rcpwd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .clock_period_us (clock_period_us),
        .in_valid        (push && !full),
        .command         (command),
        .pulse_level     (pulse_level),
        .pulse_width_us  (pulse_width_us),
        .cls             (cls_in)
    );

    // classified beats
    rcpwd_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls_in),
        .full      (full),
        .pop       (cls_pop),
        .head      (cls_head_bits),
        .empty     (cls_empty)
    );

    assign cls_head = pulse_class_t'(cls_head_bits);

    // sequencer
    rcpwd_back #(
        .SYNC_TRIES (SYNC_TRIES),
        .DATA_BITS  (DATA_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (!cls_empty),
        .cls       (cls_head),
        .cls_pop   (cls_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result beats
    rcpwd_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .head      (res_head_bits),
        .empty     (empty)
    );

    assign res_head  = result_t'(res_head_bits);
    assign status    = res_head.status;
    assign code_word = res_head.code;

endmodule

[rtl/rcpwd_queue.sv]
// ----------------------------------------------------------------------------
// rcpwd_queue: small synchronous FIFO
// Register-based queue with push/full and pop/empty; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module rcpwd_queue
    import rcpwd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy never exceeds depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

endmodule

[rtl/rcpwd_front.sv]
// ----------------------------------------------------------------------------
// rcpwd_front: window setup and pulse classifier
// Holds the width windows derived from the clock period and classifies each
// accepted beat against every window before it enters the class queue.
// ----------------------------------------------------------------------------
module rcpwd_front
    import rcpwd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // config
    input  logic               cfg_wr_en,
    input  logic [CLK_W-1:0]   clock_period_us,
    // input beat
    input  logic               in_valid,
    input  logic               command,
    input  logic               pulse_level,
    input  logic [WIDTH_W-1:0] pulse_width_us,
    // class queue side
    output pulse_class_t       cls
);

    logic [BOUND_W-1:0] lower_reg;
    logic [BOUND_W-1:0] upper_reg;
    logic [GAP_W-1:0]   gap_reg;

    logic [WIDTH_W-1:0] w;
    logic [WIDTH_W-1:0] lo, hi, lo2, hi2, sync_lo, sync_hi, gap_lim;

    // window bounds, recomputed on a config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= lower_of(CLK_PERIOD_RESET);
            upper_reg <= upper_of(CLK_PERIOD_RESET);
            gap_reg   <= gap_of(CLK_PERIOD_RESET);
        end
        else if (cfg_wr_en)
        begin
            lower_reg <= lower_of(clock_period_us);
            upper_reg <= upper_of(clock_period_us);
            gap_reg   <= gap_of(clock_period_us);
        end
    end

    // scaled windows: x2 for a zero bit, x36 for sync
    assign lo      = WIDTH_W'(lower_reg);
    assign hi      = WIDTH_W'(upper_reg);
    assign lo2     = lo << 1;
    assign hi2     = hi << 1;
    assign sync_lo = (lo << 5) + (lo << 2);
    assign sync_hi = (hi << 5) + (hi << 2);
    assign gap_lim = WIDTH_W'(gap_reg);

    // a timeout beat counts as a zero-width pulse
    assign w = command ? '0 : pulse_width_us;

    // classification
    always_comb
    begin
        cls          = '0;
        cls.timeout  = command;
        cls.high     = pulse_level;
        cls.sync_hit = (w > sync_lo) && (w < sync_hi);
        cls.gap_over = (w > gap_lim);
        cls.bit_one  = (w > lo) && (w < hi);
        cls.bit_zero = (w > lo2) && (w < hi2);
    end

    // a timeout beat never passes a bit window or the gap limit test
    a_timeout_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && command |-> !cls.bit_one && !cls.bit_zero && !cls.gap_over)
        else $error("timeout beat classified as a pulse");

endmodule

[rtl/rcpwd_back.sv]
// ----------------------------------------------------------------------------
// rcpwd_back: decode sequencer
// Walks the hunt / gap / data phases on classified beats, shifts in data
// bits and pushes one result beat on every terminal event.
// ----------------------------------------------------------------------------
module rcpwd_back
    import rcpwd_pkg::*;
#(
    parameter int SYNC_TRIES = SYNC_TRIES_DEF,
    parameter int DATA_BITS  = DATA_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // class queue
    input  logic         cls_valid,
    input  pulse_class_t cls,
    output logic         cls_pop,
    // result queue
    input  logic         res_full,
    output logic         res_push,
    output result_t      res
);

    localparam int TRY_W = $clog2(SYNC_TRIES + 1);
    localparam int BIT_W = $clog2(DATA_BITS + 1);

    phase_t               phase_reg, phase_next;
    logic [TRY_W-1:0]     tries_reg, tries_next;
    logic [BIT_W-1:0]     bits_reg, bits_next;
    logic [DATA_BITS-1:0] word_reg, word_next;

    logic                 fire;
    logic [TRY_W-1:0]     tries_inc;
    logic [BIT_W-1:0]     bits_inc;
    logic [DATA_BITS-1:0] word_shift;

    assign fire      = cls_valid && !res_full;
    assign cls_pop   = fire;
    assign tries_inc = tries_reg + 1'b1;
    assign bits_inc  = bits_reg + 1'b1;
    assign word_shift = (word_reg << 1) | DATA_BITS'(cls.bit_one);

    // next state and result
    always_comb
    begin
        phase_next = phase_reg;
        tries_next = tries_reg;
        bits_next  = bits_reg;
        word_next  = word_reg;
        res_push   = 1'b0;
        res        = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_GAP:
                begin
                    if (cls.timeout || (cls.high && cls.gap_over))
                    begin
                        res_push   = 1'b1;
                        res.status = ST_NOSYNC;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (cls.timeout || cls.high)
                    begin
                        if (cls.bit_one || cls.bit_zero)
                        begin
                            word_next = word_shift;
                            bits_next = bits_inc;
                            if (bits_inc >= BIT_W'(DATA_BITS))
                            begin
                                res_push   = 1'b1;
                                res.status = ST_OK;
                                res.code   = CODE_W'({{CODE_W{1'b0}}, word_shift});
                            end
                        end
                        else
                        begin
                            res_push   = 1'b1;
                            res.status = ST_NODATA;
                        end
                    end
                end
                default:
                begin
                    // hunting; unused codes fall back here
                    phase_next = PH_HUNT;
                    if (cls.timeout)
                    begin
                        res_push   = 1'b1;
                        res.status = ST_TIMEOUT;
                    end
                    else if (!cls.high)
                    begin
                        if (cls.sync_hit)
                        begin
                            phase_next = PH_GAP;
                            tries_next = '0;
                            bits_next  = '0;
                            word_next  = '0;
                        end
                        else
                        begin
                            tries_next = tries_inc;
                            if (tries_inc >= TRY_W'(SYNC_TRIES))
                            begin
                                res_push   = 1'b1;
                                res.status = ST_TIMEOUT;
                            end
                        end
                    end
                end
            endcase

            // every result returns to hunt with counters cleared
            if (res_push)
            begin
                phase_next = PH_HUNT;
                tries_next = '0;
                bits_next  = '0;
                word_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            tries_reg <= '0;
            bits_reg  <= '0;
            word_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tries_reg <= tries_next;
            bits_reg  <= bits_next;
            word_reg  <= word_next;
        end
    end

    // error results carry a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.status != ST_OK |-> res.code == '0)
        else $error("error result with nonzero word");

    // a result always sends the sequencer back to hunt
    a_result_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> phase_reg == PH_HUNT && tries_reg == '0 && bits_reg == '0)
        else $error("state not cleared after result");

    // counters stay below their terminal counts between beats
    a_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tries_reg < TRY_W'(SYNC_TRIES) && bits_reg < BIT_W'(DATA_BITS))
        else $error("counter reached terminal count without result");

    // no result is pushed into a full queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full && cls_valid)
        else $error("result pushed without room or input");

endmodule

[dv/remote_code_pulse_width_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// remote_code_pulse_width_decoder_tb: self-checking bench for the code decoder
// Drives measured pulses and timeout events through the input queue. It keeps
// its own model of the sync hunt, gap check and bit windows, and compares
// every result beat with the predicted status and word. Directed cases cover
// hunt and gap corners and a data-phase timeout. A sweep of clock periods
// includes zero and full scale. A long output stall fills the block, then
// random frames with noise and broken pulses run at random idle on both sides.
// ----------------------------------------------------------------------------
module remote_code_pulse_width_decoder_tb;
    import rcpwd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 250;
    localparam int RANDOM_BEATS  = 560;
    localparam int QUIET_BEATS   = 150;
    localparam int CFG_EVERY     = 120;
    localparam int IDLE_PCT      = 13;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_CYCLES  = 400000;

    // command and level codes
    localparam bit CMD_PULSE   = 1'b0;
    localparam bit CMD_TIMEOUT = 1'b1;
    localparam bit LVL_LOW     = 1'b0;
    localparam bit LVL_HIGH    = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CLK_W-1:0]   clock_period_us;
    logic               push;
    logic               full;
    logic               command;
    logic               pulse_level;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic               empty;
    logic               pop;
    logic [1:0]         status;
    logic [CODE_W-1:0]  code_word;

    // decoder shadow state
    phase_t             dec_phase;
    int unsigned        miss_count;
    int unsigned        bit_count;
    logic [CODE_W-1:0]  shift_reg;
    logic [CLK_W-1:0]   period_us;

    result_t            expected_words[$];
    int unsigned        n_beats_sent;
    int unsigned        n_errors;
    int unsigned        cycle_count;
    bit                 no_idle;
    bit                 hold_req;

    remote_code_pulse_width_decoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .clock_period_us (clock_period_us),
        .push            (push),
        .full            (full),
        .command         (command),
        .pulse_level     (pulse_level),
        .pulse_width_us  (pulse_width_us),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .code_word       (code_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------------
    function automatic void clear_frame();
        dec_phase  = PH_HUNT;
        miss_count = 0;
        bit_count  = 0;
        shift_reg  = '0;
    endfunction

    function automatic bit close_frame(input status_t st, output result_t res);
        res.status = st;
        res.code   = (st == ST_OK) ? shift_reg : '0;
        clear_frame();
        return 1'b1;
    endfunction

    // returns 1 when the beat completes a result
    function automatic bit decode_beat(input bit cmd, input bit lvl,
                                       input logic [WIDTH_W-1:0] width,
                                       output result_t res);
        longint unsigned w;
        longint unsigned c;
        longint unsigned lo;
        longint unsigned hi;
        bit              b;
        w   = width;
        c   = period_us;
        lo  = (c * 4) / 5;
        hi  = (c * 6) / 5;
        res = '0;
        case (dec_phase)
            PH_GAP:
            begin
                if (cmd == CMD_TIMEOUT)
                    return close_frame(ST_NOSYNC, res);
                if (lvl == LVL_HIGH && w > 10 * c)
                    return close_frame(ST_NOSYNC, res);
                // a low pulse ends the gap as well
                dec_phase = PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                // timeout counts as a zero-width high pulse
                if (cmd == CMD_TIMEOUT)
                    w = 0;
                else if (lvl == LVL_LOW)
                    return 1'b0;
                if (w > lo && w < hi)
                    b = 1'b1;
                else if (w > 2 * lo && w < 2 * hi)
                    b = 1'b0;
                else
                    return close_frame(ST_NODATA, res);
                shift_reg = {shift_reg[CODE_W-2:0], b};
                bit_count++;
                if (bit_count >= DATA_BITS_DEF)
                    return close_frame(ST_OK, res);
                return 1'b0;
            end
            default:
            begin
                dec_phase = PH_HUNT;
                if (cmd == CMD_TIMEOUT)
                    return close_frame(ST_TIMEOUT, res);
                if (lvl == LVL_HIGH)
                    return 1'b0;
                if (w > 36 * lo && w < 36 * hi)
                begin
                    clear_frame();
                    dec_phase = PH_GAP;
                    return 1'b0;
                end
                miss_count++;
                if (miss_count >= SYNC_TRIES_DEF)
                    return close_frame(ST_TIMEOUT, res);
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [WIDTH_W-1:0] random_width();
        return WIDTH_W'($urandom);
    endfunction

    // random width strictly inside (lo, hi); noise when the window is empty
    function automatic logic [WIDTH_W-1:0] pick_between(input longint unsigned lo,
                                                        input longint unsigned hi);
        if (hi > lo + 1)
            return WIDTH_W'(lo + 1 + $urandom_range(32'(hi - lo - 2)));
        return random_width();
    endfunction

    function automatic longint unsigned lower_bound();
        return (longint'(period_us) * 4) / 5;
    endfunction

    function automatic longint unsigned upper_bound();
        return (longint'(period_us) * 6) / 5;
    endfunction

    // one input beat; called and returns at a falling edge, push left high
    task automatic send_beat(input bit cmd, input bit lvl, input logic [WIDTH_W-1:0] width);
        result_t res;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push           <= 1'b1;
        command        <= cmd;
        pulse_level    <= lvl;
        pulse_width_us <= width;
        do
            @(posedge clk);
        while (full);
        n_beats_sent++;
        if (decode_beat(cmd, lvl, width, res))
            expected_words.push_back(res);
        @(negedge clk);
    endtask

    task automatic send_timeout();
        send_beat(CMD_TIMEOUT, 1'($urandom), random_width());
    endtask

    // stop offering beats and wait until every result is back
    task automatic drain_block();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_clock_period(input logic [CLK_W-1:0] value);
        cfg_wr_en       <= 1'b1;
        clock_period_us <= value;
        @(negedge clk);
        cfg_wr_en       <= 1'b0;
        period_us        = value;
    endtask

    // sync, gap and data bits, with occasional noise and broken pulses
    task automatic send_frame();
        longint unsigned c;
        longint unsigned lo;
        longint unsigned hi;
        int              r;
        c  = period_us;
        lo = lower_bound();
        hi = upper_bound();
        repeat ($urandom_range(2)) send_beat(CMD_PULSE, LVL_HIGH, random_width());
        // sync low
        if ($urandom_range(99) < 4)
            send_beat(CMD_PULSE, LVL_LOW, WIDTH_W'($urandom_range(1) ? 36 * lo : 36 * hi));
        else
            send_beat(CMD_PULSE, LVL_LOW, pick_between(36 * lo, 36 * hi));
        if (dec_phase != PH_GAP)
            return;
        // high gap after sync
        r = $urandom_range(99);
        if (r < 70)
            send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'($urandom_range(32'(10 * c))));
        else if (r < 80)
            send_beat(CMD_PULSE, LVL_LOW, random_width());
        else if (r < 86)
            send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'(10 * c + $urandom_range(1)));
        else if (r < 92)
            send_timeout();
        else
            send_beat(CMD_PULSE, LVL_HIGH, random_width());
        // data bits until the word or an error closes the frame
        while (dec_phase == PH_DATA)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_beat(CMD_PULSE, LVL_LOW, random_width());
            else if (r < 9)
                send_timeout();
            else if (r < 11)
            begin
                case ($urandom_range(3))
                    0:       send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'(lo));
                    1:       send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'(hi));
                    2:       send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'(2 * lo));
                    default: send_beat(CMD_PULSE, LVL_HIGH, WIDTH_W'(2 * hi));
                endcase
            end
            else if (r < 12)
                send_beat(CMD_PULSE, LVL_HIGH, random_width());
            else if (r < 56)
                send_beat(CMD_PULSE, LVL_HIGH, pick_between(lo, hi));
            else
                send_beat(CMD_PULSE, LVL_HIGH, pick_between(2 * lo, 2 * hi));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: pop pacing and checking
    // ------------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
                report_error($sformatf("unexpected beat status=%0d code=%03h",
                                       status, code_word));
            else
            begin
                want = expected_words.pop_front();
                if (status !== want.status || code_word !== want.code)
                    report_error($sformatf("status exp %0d got %0d, code exp %03h got %03h",
                                           want.status, status, want.code, code_word));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // hunt: timeout event, ignored high, misses up to the retry limit
    task automatic test_hunt_cases();
        longint unsigned lo;
        longint unsigned hi;
        lo = lower_bound();
        hi = upper_bound();
        send_beat(CMD_TIMEOUT, LVL_HIGH, '1);
        send_beat(CMD_PULSE, LVL_HIGH, '1);
        send_beat(CMD_PULSE, LVL_LOW, '0);
        send_beat(CMD_PULSE, LVL_LOW, '1);
        send_beat(CMD_PULSE, LVL_LOW, WIDTH_W'(36 * lo));
        send_beat(CMD_PULSE, LVL_LOW, WIDTH_W'(36 * hi));
        repeat (SYNC_TRIES_DEF - 4)
            send_beat(CMD_PULSE, LVL_LOW, WIDTH_W'($urandom_range(32'(36 * lo))));
        drain_block();
    endtask

    // gap: timeout, over-long high, low ending gap, ignored data low, timeout
    task automatic test_gap_cases();
        longint unsigned lo;
        longint unsigned hi;
        lo = lower_bound();
        hi = upper_bound();
        send_beat(CMD_PULSE, LVL_LOW, pick_between(36 * lo, 36 * hi));
        send_timeout();
        send_beat(CMD_PULSE, LVL_LOW, pick_between(36 * lo, 36 * hi));
        send_beat(CMD_PULSE, LVL_HIGH, '1);
        send_beat(CMD_PULSE, LVL_LOW, pick_between(36 * lo, 36 * hi));
        send_beat(CMD_PULSE, LVL_LOW, '0);
        send_beat(CMD_PULSE, LVL_LOW, '1);
        send_timeout();
        drain_block();
    endtask

    // clock period sweep including zero and full scale
    task automatic test_clock_extremes();
        logic [CLK_W-1:0] settings[6];
        settings = '{16'd1, 16'd50000, 16'hFFFF, 16'd0, 16'd2, 16'd5};
        foreach (settings[i])
        begin
            write_clock_period(settings[i]);
            repeat (4) send_frame();
            send_timeout();
            drain_block();
        end
        write_clock_period(CLK_PERIOD_RESET);
    endtask

    // long output stall while timeouts keep coming, input must back up
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (16) send_timeout();
        drain_block();
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned next_cfg;
        int          r;
        start    = n_beats_sent;
        next_cfg = CFG_EVERY;
        no_idle  = 1'b1;
        while (n_beats_sent - start < RANDOM_BEATS)
        begin
            if (n_beats_sent - start >= QUIET_BEATS)
                no_idle = 1'b0;
            if (n_beats_sent - start >= next_cfg)
            begin
                drain_block();
                r = $urandom_range(99);
                if (r < 10)
                    write_clock_period($urandom_range(1) ? 16'hFFFF : CLK_W'($urandom_range(2)));
                else if (r < 35)
                    write_clock_period(CLK_W'($urandom));
                else
                    write_clock_period(CLK_W'($urandom_range(1500, 150)));
                next_cfg += CFG_EVERY;
            end
            r = $urandom_range(99);
            if (r < 80)
                send_frame();
            else if (r < 88)
                send_timeout();
            else
                send_beat(CMD_PULSE, 1'($urandom), random_width());
        end
        drain_block();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        clock_period_us = CLK_PERIOD_RESET;
        push            = 1'b0;
        command         = CMD_PULSE;
        pulse_level     = LVL_LOW;
        pulse_width_us  = '0;
        n_beats_sent    = 0;
        n_errors        = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        period_us       = CLK_PERIOD_RESET;
        clear_frame();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_hunt_cases();
        test_gap_cases();
        test_clock_extremes();
        test_output_backpressure();
        test_random_frames();

        if (expected_words.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_words.size()));
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/rcpwd_pkg.sv
rtl/rcpwd_queue.sv
rtl/rcpwd_front.sv
rtl/rcpwd_back.sv
rtl/remote_code_pulse_width_decoder.sv
dv/remote_code_pulse_width_decoder_tb.sv
